// ===== rtl/contiguous_page_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Contiguous page allocator assertion macros
// Shared concurrent check forms, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define CPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpa: same-cycle check failed");

// consequence must hold in the cycle after the antecedent
`define CPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpa: next-cycle check failed");

`endif

// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Types and constants shared by the contiguous page allocator modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// fixed field widths
	localparam int ADDR_W    = 32;
	localparam int REQ_W     = 11;
	localparam int COUNT_W   = 11;
	localparam int FLAG_W    = 2;
	localparam int REG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// per-page descriptor flags
	localparam logic [FLAG_W-1:0] FLAG_FREE  = 2'b00;
	localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
	localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_FAIL    = 2'd1,
		STATUS_IGNORED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FILL,
		ST_WALK,
		ST_REPLY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;   // zero one descriptor, advance pointer
		logic load;    // capture request fields
		logic prep;    // range check result, set up pointers
		logic scan;    // first-fit search step
		logic fill;    // mark one page of the found run
		logic walk;    // free walk step
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic reject;
		logic mode_free;
		logic hit;
		logic scan_end;
		logic fill_last;
		logic walk_end;
	} sts_t;

endpackage

// ===== rtl/cpa_ram.sv =====
// ----------------------------------------------------------------------------
// cpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for the page allocator: clear pass, check, search, fill, walk.
// ----------------------------------------------------------------------------
module cpa_ctrl
	import cpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (sts.reject) state_nxt = ST_REPLY;
				else if (sts.mode_free) state_nxt = ST_WALK;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				priority if (sts.hit) state_nxt = ST_FILL;
				else if (sts.scan_end) state_nxt = ST_REPLY;
				else state_nxt = ST_SCAN;
			end
			ST_FILL: begin
				if (sts.fill_last) state_nxt = ST_REPLY;
			end
			ST_WALK: begin
				if (sts.walk_end) state_nxt = ST_REPLY;
			end
			ST_REPLY: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CHECK: cmd.prep = 1'b1;
			ST_SCAN:  cmd.scan = 1'b1;
			ST_FILL:  cmd.fill = 1'b1;
			ST_WALK:  cmd.walk = 1'b1;
			ST_REPLY: done = 1'b1;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/cpa_dp.sv =====
// ----------------------------------------------------------------------------
// cpa_dp
// Allocator datapath: config registers, descriptor RAM, pointers and counters.
// ----------------------------------------------------------------------------
module cpa_dp
	import cpa_pkg::*;
#(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 mode,
	input  logic [REQ_W-1:0]     page_request,
	input  logic [ADDR_W-1:0]    free_address,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [ADDR_W-1:0]    block_address,
	output logic [1:0]           status
);

	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int NW = (CW > REQ_W) ? CW : REQ_W;
	localparam int SW = (NW + PAGE_SHIFT > ADDR_W) ? NW + PAGE_SHIFT : ADDR_W;
	localparam int EW = SW + 1;
	localparam logic [NW-1:0] MAX_N  = NW'(MAX_PAGES);
	localparam logic [NW-1:0] LAST_N = NW'(MAX_PAGES - 1);

	// configuration
	logic [ADDR_W-1:0]  base_q;
	logic [COUNT_W-1:0] count_q;

	// captured request
	logic              mode_q;
	logic [NW-1:0]     want_q;
	logic [ADDR_W-1:0] addr_q;
	logic [NW-1:0]     pages_q;

	// walk / search pointers
	logic [NW-1:0] ptr_q;
	logic [NW-1:0] pg_s1;
	logic          vld_s1;
	logic [NW-1:0] run_q;
	logic [NW-1:0] start_q;
	logic [NW-1:0] end_q;
	logic [NW-1:0] fill_q;

	logic [ADDR_W-1:0] block_address_q;
	status_t           status_q;

	// RAM port signals
	logic              wr_en;
	logic [PW-1:0]     wr_addr;
	logic [FLAG_W-1:0] wr_data;
	logic [FLAG_W-1:0] rd_flags;

	// combinational terms
	logic [NW-1:0] pool_pages;
	logic [EW-1:0] pool_end;
	logic [EW-1:0] addr_off;
	logic [EW-1:0] off_pages;
	logic [NW-1:0] idx_start;
	logic          free_rej;
	logic          alloc_rej;
	logic          reject;
	logic          issue_ok;
	logic          flag_taken;
	logic          flag_last;
	logic [NW-1:0] run_nxt;
	logic [NW-1:0] run_start;
	logic          hit;

	cpa_ram #(
		.WIDTH (FLAG_W),
		.DEPTH (MAX_PAGES)
	) u_flags (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ptr_q[PW-1:0]),
		.rd_data (rd_flags)
	);

	// pool size clamp and range checks
	assign pool_pages = (NW'(count_q) > MAX_N) ? MAX_N : NW'(count_q);
	assign pool_end   = EW'(base_q) + (EW'(pages_q) << PAGE_SHIFT);
	assign addr_off   = EW'(addr_q) - EW'(base_q);
	assign off_pages  = addr_off >> PAGE_SHIFT;
	assign idx_start  = off_pages[NW-1:0];
	assign free_rej   = (addr_q < base_q) || (EW'(addr_q) >= pool_end);
	assign alloc_rej  = (want_q == '0) || (want_q > pages_q);
	assign reject     = (mode_q == MODE_FREE) ? free_rej : alloc_rej;

	// descriptor decode of the page read last cycle
	assign issue_ok   = ptr_q < pages_q;
	assign flag_taken = |(rd_flags & FLAG_TAKEN);
	assign flag_last  = |(rd_flags & FLAG_LAST);
	assign run_nxt    = run_q + NW'(1);
	assign run_start  = pg_s1 + NW'(1) - want_q;
	assign hit        = vld_s1 && !flag_taken && (run_nxt == want_q);

	// status to controller
	always_comb begin
		sts           = '0;
		sts.clr_last  = ptr_q == LAST_N;
		sts.reject    = reject;
		sts.mode_free = mode_q == MODE_FREE;
		sts.hit       = hit;
		sts.scan_end  = !vld_s1 && !issue_ok;
		sts.fill_last = fill_q == end_q;
		sts.walk_end  = vld_s1 ? (!flag_taken || flag_last) : !issue_ok;
	end

	// descriptor write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[PW-1:0];
		wr_data = FLAG_FREE;
		priority if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (cmd.fill) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[PW-1:0];
			wr_data = (fill_q == end_q) ? (FLAG_TAKEN | FLAG_LAST) : FLAG_TAKEN;
		end else if (cmd.walk) begin
			wr_en   = vld_s1 && flag_taken;
			wr_addr = pg_s1[PW-1:0];
		end else begin
			wr_en = 1'b0;
		end
	end

	// config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= COUNT_RESET;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_BASE:  base_q  <= cfg_data;
					REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default: begin
						base_q <= base_q;
					end
				endcase
			end
			priority if (cmd.clear) begin
				ptr_q <= ptr_q + NW'(1);
			end else if (cmd.prep) begin
				ptr_q  <= (mode_q == MODE_FREE) ? idx_start : '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan || cmd.walk) begin
				ptr_q  <= ptr_q + NW'(issue_ok);
				vld_s1 <= issue_ok;
			end else begin
				vld_s1 <= vld_s1;
			end
		end
	end

	// request payload and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			want_q  <= NW'(page_request);
			addr_q  <= free_address;
			pages_q <= pool_pages;
		end
		if (cmd.prep) begin
			run_q           <= '0;
			block_address_q <= '0;
			if (reject) begin
				status_q <= (mode_q == MODE_FREE) ? STATUS_IGNORED : STATUS_FAIL;
			end else begin
				status_q <= (mode_q == MODE_FREE) ? STATUS_DONE : STATUS_FAIL;
			end
		end
		if (cmd.scan || cmd.walk) begin
			pg_s1 <= ptr_q;
		end
		// first-fit run counting
		if (cmd.scan && vld_s1) begin
			run_q <= flag_taken ? '0 : run_nxt;
			if (hit) begin
				start_q  <= run_start;
				fill_q   <= run_start;
				end_q    <= pg_s1;
				status_q <= STATUS_DONE;
			end
		end
		if (cmd.fill) begin
			fill_q          <= fill_q + NW'(1);
			block_address_q <= base_q + (ADDR_W'(start_q) << PAGE_SHIFT);
		end
	end

	assign block_address = block_address_q;
	assign status        = status_q;

endmodule

// ===== rtl/contiguous_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator_core
// First-fit contiguous page allocator with per-page taken/last descriptors.
// ----------------------------------------------------------------------------
// Usage:
//  A request is taken when start is high while busy is low. mode selects
//  allocate (page_request pages) or free (block at free_address).
//  The result appears on block_address and status for exactly one cycle
//  with done high; the receiver cannot stall it, so it must be captured then.
//  Configuration (base_address index 0, page_count index 1) is written with
//  cfg_write/cfg_index/cfg_data; the user must do so only while busy is low,
//  as the block itself does not enforce it. A rejected request goes from
//  the check state straight to the reply. An allocation searches the
//  descriptor RAM one page per cycle from page 0, then marks the found run
//  one page per cycle. A free walks one page per cycle from the freed page.
//  The single read port of the descriptor RAM sets this pace; one request
//  is in flight at a time. After reset the descriptor RAM is cleared one
//  entry per cycle, and busy stays high until every entry is cleared; only
//  then is the first request taken.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_core_macros.svh"

module contiguous_page_allocator_core
	import cpa_pkg::*;
#(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [REQ_W-1:0]     page_request,
	input  logic [ADDR_W-1:0]    free_address,
	output logic                 done,
	output logic [ADDR_W-1:0]    block_address,
	output logic [1:0]           status
);

	cmd_t cmd;
	sts_t sts;

	cpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cpa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.page_request  (page_request),
		.free_address  (free_address),
		.cmd           (cmd),
		.sts           (sts),
		.block_address (block_address),
		.status        (status)
	);

	// checks
	`CPA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`CPA_ASSERT_NEXT(a_done_returns_idle, done, !busy)
	`CPA_ASSERT_NOW(a_status_legal, done, status <= STATUS_IGNORED)
	`CPA_ASSERT_NOW(a_fail_zero_addr, done && (status != STATUS_DONE), block_address == '0)

endmodule
